// ----- hw/rtl/lucw_pkg.sv -----
// Shared constants for the longest unique character window block.
// No dependencies; every other file of the block but lucw_pos_mem refers to this package.
package lucw_pkg;

    // Default sizing of the position counter and the character table.
    localparam int POSITION_BITS = 16;
    localparam int ALPHABET_SIZE = 256;

    // Fixed widths of the transfer fields.
    localparam int CHAR_W     = 8;
    localparam int CHAR_COUNT = 256;
    localparam int OUT_W      = 16;

    // Largest value the result fields can carry before saturating.
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

endpackage

// ----- hw/rtl/lucw_in_if.sv -----
// Character channel: one byte of a string per transfer, with a final-byte flag.
// Depends on lucw_pkg for the field widths.
interface lucw_in_if;

    logic                        valid;
    logic                        ready;
    logic [lucw_pkg::CHAR_W-1:0] char_byte;
    logic                        is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);

endinterface

// ----- hw/rtl/lucw_out_if.sv -----
// Result channel: start and length of the longest window, with an overflow flag.
// Depends on lucw_pkg for the field widths.
interface lucw_out_if;

    logic                       valid;
    logic                       ready;
    logic [lucw_pkg::OUT_W-1:0] best_start;
    logic [lucw_pkg::OUT_W-1:0] best_length;
    logic                       overflow;

    modport source (output valid, output best_start, output best_length,
                    output overflow, input ready);
    modport sink   (input valid, input best_start, input best_length,
                    input overflow, output ready);

endinterface

// ----- hw/rtl/lucw_pos_mem.sv -----
// Last-seen position table: one write port, one registered read port.
// No package dependency; sized entirely by its parameters.
module lucw_pos_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // A read and a write to the same entry in one cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lucw_scan.sv -----
// Window tracker: issues table reads, forwards the latest write, updates the window.
// Depends on lucw_pkg; drives lucw_pos_mem and hands finished strings to lucw_result.
module lucw_scan #(
    parameter int POSITION_BITS = lucw_pkg::POSITION_BITS,
    parameter int ALPHABET_SIZE = lucw_pkg::ALPHABET_SIZE,
    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lucw_pkg::CHAR_W-1:0] char_byte,
    input  logic                        is_last,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [POSITION_BITS-1:0]    rd_data,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [POSITION_BITS-1:0]    wr_data,
    output logic                        fin_load,
    input  logic                        fin_free,
    output logic [POSITION_BITS-1:0]    fin_best_start,
    output logic [POSITION_BITS-1:0]    fin_best_length,
    output logic [POSITION_BITS-1:0]    fin_window_start,
    output logic [POSITION_BITS-1:0]    fin_end,
    output logic                        fin_overflow
);

    localparam int P = POSITION_BITS;

    logic [IDX_W-1:0] mod_lut [lucw_pkg::CHAR_COUNT];

    logic                     s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]         s1_idx_reg, s1_idx_next;
    logic                     s1_last_reg, s1_last_next;
    logic [ALPHABET_SIZE-1:0] seen_reg, seen_next;
    logic [P-1:0]             pos_reg, pos_next;
    logic [P-1:0]             ws_reg, ws_next;
    logic [P-1:0]             best_start_reg, best_start_next;
    logic [P-1:0]             best_len_reg, best_len_next;
    logic                     ovf_reg, ovf_next;
    logic                     fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]         fwd_idx_reg, fwd_idx_next;
    logic [P-1:0]             fwd_pos_reg, fwd_pos_next;

    logic         stall;
    logic         commit;
    logic         drop;
    logic         hit;
    logic         upd;
    logic [P-1:0] last_pos;
    logic [P-1:0] run_len;
    logic [P-1:0] ws_a;
    logic [P-1:0] bs_a;
    logic [P-1:0] bl_a;
    logic [P-1:0] pos_a;
    logic         ovf_a;

    // Byte to table index; a constant lookup, trivial when the alphabet is a power of two.
    for (genvar g = 0; g < lucw_pkg::CHAR_COUNT; g++)
    begin : g_mod
        assign mod_lut[g] = IDX_W'(g % ALPHABET_SIZE);
    end

    // A final byte waits here only while the result path is full.
    assign stall    = s1_valid_reg && s1_last_reg && !fin_free;
    assign in_ready = !stall;
    assign rd_en    = in_valid && !stall;
    assign rd_addr  = mod_lut[char_byte];
    assign commit   = s1_valid_reg && !stall;
    assign drop     = &pos_reg;

    // The table read misses the write committed on the same edge; take it from here.
    assign last_pos = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_pos_reg : rd_data;
    assign hit      = !drop && seen_reg[s1_idx_reg] && (last_pos >= ws_reg);
    assign run_len  = pos_reg - ws_reg;
    assign upd      = hit && (run_len > best_len_reg);
    assign ws_a     = hit ? (last_pos + P'(1)) : ws_reg;
    assign bs_a     = upd ? ws_reg : best_start_reg;
    assign bl_a     = upd ? run_len : best_len_reg;
    assign pos_a    = drop ? pos_reg : (pos_reg + P'(1));
    assign ovf_a    = ovf_reg || drop;

    assign wr_en   = commit && !drop;
    assign wr_addr = s1_idx_reg;
    assign wr_data = pos_reg;

    assign fin_load         = commit && s1_last_reg;
    assign fin_best_start   = bs_a;
    assign fin_best_length  = bl_a;
    assign fin_window_start = ws_a;
    assign fin_end          = pos_a;
    assign fin_overflow     = ovf_a;

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        s1_last_next    = s1_last_reg;
        seen_next       = seen_reg;
        pos_next        = pos_reg;
        ws_next         = ws_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        fwd_valid_next  = fwd_valid_reg;
        fwd_idx_next    = fwd_idx_reg;
        fwd_pos_next    = fwd_pos_reg;

        if (!stall)
        begin
            s1_valid_next  = in_valid;
            s1_idx_next    = rd_addr;
            s1_last_next   = is_last;
            fwd_valid_next = wr_en;
            fwd_idx_next   = s1_idx_reg;
            fwd_pos_next   = pos_reg;
        end

        if (commit)
        begin
            if (s1_last_reg)
            begin
                seen_next       = '0;
                pos_next        = '0;
                ws_next         = '0;
                best_start_next = '0;
                best_len_next   = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                if (!drop)
                begin
                    seen_next[s1_idx_reg] = 1'b1;
                end
                pos_next        = pos_a;
                ws_next         = ws_a;
                best_start_next = bs_a;
                best_len_next   = bl_a;
                ovf_next        = ovf_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            seen_reg       <= '0;
            pos_reg        <= '0;
            ws_reg         <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s1_last_reg    <= s1_last_next;
            seen_reg       <= seen_next;
            pos_reg        <= pos_next;
            ws_reg         <= ws_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= s1_idx_next;
        fwd_idx_reg <= fwd_idx_next;
        fwd_pos_reg <= fwd_pos_next;
    end

endmodule

// ----- hw/rtl/lucw_result.sv -----
// Result stage: scores the closing window, saturates and holds the outgoing result.
// Depends on lucw_pkg for the output width and saturation limit.
module lucw_result #(
    parameter int POSITION_BITS = lucw_pkg::POSITION_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fin_load,
    output logic                       fin_free,
    input  logic [POSITION_BITS-1:0]   fin_best_start,
    input  logic [POSITION_BITS-1:0]   fin_best_length,
    input  logic [POSITION_BITS-1:0]   fin_window_start,
    input  logic [POSITION_BITS-1:0]   fin_end,
    input  logic                       fin_overflow,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lucw_pkg::OUT_W-1:0] best_start,
    output logic [lucw_pkg::OUT_W-1:0] best_length,
    output logic                       overflow
);

    localparam int P     = POSITION_BITS;
    localparam int OUT_W = lucw_pkg::OUT_W;
    localparam int EXT_W = (P > OUT_W) ? P : OUT_W;

    logic             fin_valid_reg, fin_valid_next;
    logic [P-1:0]     fin_bs_reg, fin_bl_reg, fin_ws_reg, fin_end_reg;
    logic             fin_ovf_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_start_reg, out_length_reg;
    logic             out_ovf_reg;

    logic             out_load;
    logic [P-1:0]     tail_len;
    logic [P-1:0]     sel_start;
    logic [P-1:0]     sel_len;
    logic [EXT_W-1:0] start_ext;
    logic [EXT_W-1:0] len_ext;
    logic             start_sat;
    logic             len_sat;

    assign out_load = fin_valid_reg && (!out_valid_reg || out_ready);
    assign fin_free = !fin_valid_reg || out_load;

    // The window still open at the final byte competes on equal terms, later loses ties.
    assign tail_len  = fin_end_reg - fin_ws_reg;
    assign sel_start = (tail_len > fin_bl_reg) ? fin_ws_reg : fin_bs_reg;
    assign sel_len   = (tail_len > fin_bl_reg) ? tail_len : fin_bl_reg;
    assign start_ext = EXT_W'(sel_start);
    assign len_ext   = EXT_W'(sel_len);
    assign start_sat = start_ext > EXT_W'(lucw_pkg::OUT_MAX);
    assign len_sat   = len_ext > EXT_W'(lucw_pkg::OUT_MAX);

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (fin_load)
        begin
            fin_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            fin_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_bs_reg  <= fin_best_start;
            fin_bl_reg  <= fin_best_length;
            fin_ws_reg  <= fin_window_start;
            fin_end_reg <= fin_end;
            fin_ovf_reg <= fin_overflow;
        end
        if (out_load)
        begin
            out_start_reg  <= start_sat ? lucw_pkg::OUT_MAX : start_ext[OUT_W-1:0];
            out_length_reg <= len_sat ? lucw_pkg::OUT_MAX : len_ext[OUT_W-1:0];
            out_ovf_reg    <= fin_ovf_reg || start_sat || len_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_start  = out_start_reg;
    assign best_length = out_length_reg;
    assign overflow    = out_ovf_reg;

endmodule

// ----- hw/rtl/longest_unique_char_window.sv -----
// Top level of the longest unique character window block.
// Depends on lucw_pkg, lucw_in_if, lucw_out_if, lucw_pos_mem, lucw_scan and lucw_result.

// The block reads a string one byte per transfer on the chars channel, the final byte
// flagged by is_last, and for each string delivers one transfer on the results channel
// giving the start and length of the first longest stretch in which no byte value repeats,
// plus an overflow flag. Unless input is held back, it takes one byte every clock cycle,
// set by the single read and single write the last-seen position table allows per cycle;
// the write of one byte is forwarded to the byte behind it, so repeated characters cost
// nothing extra. A result passes the scan stage register, the finished-string register
// and the output register after its final byte is transferred. Input is held back only
// when a final byte arrives while two earlier results still wait to be taken. Positions
// count from zero; once the position counter is full, further bytes of the string are
// ignored and overflow is raised; values over sixteen bits saturate with overflow set.
// No clearing pass is needed after reset: the per-byte seen flags are flip-flops, cleared
// at once after every string.
module longest_unique_char_window #(
    parameter int POSITION_BITS = lucw_pkg::POSITION_BITS,
    parameter int ALPHABET_SIZE = lucw_pkg::ALPHABET_SIZE
) (
    input  logic              clk,
    input  logic              rst_n,
    lucw_in_if.sink           chars,
    lucw_out_if.source        results
);

    localparam int P     = POSITION_BITS;
    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [P-1:0]     rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [P-1:0]     wr_data;

    logic             fin_load;
    logic             fin_free;
    logic [P-1:0]     fin_best_start;
    logic [P-1:0]     fin_best_length;
    logic [P-1:0]     fin_window_start;
    logic [P-1:0]     fin_end;
    logic             fin_overflow;

    // Last-seen position of every table entry; its value is only used where its seen flag is set.
    lucw_pos_mem #(
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (IDX_W),
        .DATA_W (P)
    ) u_pos_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Table lookup on acceptance, window update from the s1 stage registers when the read returns.
    lucw_scan #(
        .POSITION_BITS (POSITION_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (chars.valid),
        .in_ready         (chars.ready),
        .char_byte        (chars.char_byte),
        .is_last          (chars.is_last),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .fin_load         (fin_load),
        .fin_free         (fin_free),
        .fin_best_start   (fin_best_start),
        .fin_best_length  (fin_best_length),
        .fin_window_start (fin_window_start),
        .fin_end          (fin_end),
        .fin_overflow     (fin_overflow)
    );

    // Closing score and saturation, then the output register that parts the two sides.
    lucw_result #(
        .POSITION_BITS (POSITION_BITS)
    ) u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .fin_load         (fin_load),
        .fin_free         (fin_free),
        .fin_best_start   (fin_best_start),
        .fin_best_length  (fin_best_length),
        .fin_window_start (fin_window_start),
        .fin_end          (fin_end),
        .fin_overflow     (fin_overflow),
        .out_valid        (results.valid),
        .out_ready        (results.ready),
        .best_start       (results.best_start),
        .best_length      (results.best_length),
        .overflow         (results.overflow)
    );

    // A finished string is handed over only when the result stage has room for it.
    a_fin_room : assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |-> fin_free)
        else $error("finished string handed over while result stage full");

    // The open window never starts past the string end, and the best never exceeds it.
    a_fin_order : assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |-> (fin_window_start <= fin_end) && (fin_best_length <= fin_end))
        else $error("window bounds out of order at end of string");

    // Every string holds at least one counted byte, so a result is never empty.
    a_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.best_length != '0))
        else $error("result with zero length");

endmodule

// ----- dv/lucw_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the longest unique character window testbench.
// Depends on lucw_pkg for the sizing of the position counter and the character table.
package lucw_tb_pkg;

    import lucw_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] best_start;
        logic [OUT_W-1:0] best_length;
        logic             overflow;
    } window_result_t;

    localparam longint unsigned POS_FULL = (64'd1 << POSITION_BITS) - 64'd1;

    class lucw_window_scoreboard;

        // Own copy of the per-string state of the block.
        bit              seen[CHAR_COUNT];
        longint unsigned last_seen_at[CHAR_COUNT];
        longint unsigned char_pos;
        longint unsigned run_start;
        longint unsigned longest_start;
        longint unsigned longest_len;
        bit              pos_saturated;

        window_result_t  expected_windows[$];
        int              mismatches;

        function new();
            foreach (last_seen_at[i])
                last_seen_at[i] = 0;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (seen[i])
                seen[i] = 1'b0;
            char_pos      = 0;
            run_start     = 0;
            longest_start = 0;
            longest_len   = 0;
            pos_saturated = 1'b0;
        endfunction

        // Close the current window at end_pos; only a strictly longer one wins.
        function void close_window(longint unsigned end_pos);
            longint unsigned span;
            span = end_pos - run_start;
            if (span > longest_len)
            begin
                longest_len   = span;
                longest_start = run_start;
            end
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, logic last);
            int unsigned    slot;
            window_result_t res;
            slot = int'(c) % ALPHABET_SIZE;
            if (char_pos >= POS_FULL)
                pos_saturated = 1'b1;
            else
            begin
                if (seen[slot] && last_seen_at[slot] >= run_start)
                begin
                    close_window(char_pos);
                    run_start = last_seen_at[slot] + 1;
                end
                last_seen_at[slot] = char_pos;
                seen[slot]         = 1'b1;
                char_pos           = char_pos + 1;
            end
            if (last)
            begin
                close_window(char_pos);
                res.overflow = pos_saturated;
                if (longest_start > OUT_MAX)
                begin
                    res.best_start = OUT_MAX;
                    res.overflow   = 1'b1;
                end
                else
                    res.best_start = longest_start[OUT_W-1:0];
                if (longest_len > OUT_MAX)
                begin
                    res.best_length = OUT_MAX;
                    res.overflow    = 1'b1;
                end
                else
                    res.best_length = longest_len[OUT_W-1:0];
                expected_windows.push_back(res);
                clear_string();
            end
        endfunction

        function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
        endfunction

        function void check_result(logic [OUT_W-1:0] start, logic [OUT_W-1:0] length,
                                   logic ovf);
            window_result_t want;
            if (expected_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result: start %0d length %0d overflow %0d",
                             start, length, ovf);
                return;
            end
            want = expected_windows.pop_front();
            if (start !== want.best_start)
                flag("best_start", want.best_start, start);
            if (length !== want.best_length)
                flag("best_length", want.best_length, length);
            if (ovf !== want.overflow)
                flag("overflow", want.overflow, ovf);
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        function void check_leftovers();
            if (expected_windows.size() != 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %0d expected results never arrived",
                             expected_windows.size());
            end
        endfunction

    endclass

endpackage

// ----- dv/longest_unique_char_window_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for longest_unique_char_window.
// Depends on lucw_pkg, the two channel interfaces, the block itself and lucw_tb_pkg.
module longest_unique_char_window_tb;

    import lucw_pkg::*;
    import lucw_tb_pkg::*;

    logic clk;
    logic rst_n;

    lucw_in_if  chars();
    lucw_out_if results();

    longest_unique_char_window dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars.sink),
        .results (results.source)
    );

    lucw_window_scoreboard window_board;

    // Set by the stimulus: the receiver counts this down before it takes its next result.
    int hold_off_cycles;
    // When set, neither side inserts random gaps between transfers; a hold-off still applies.
    bit no_idle;
    int chars_sent;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Monitor. Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so a transfer is seen exactly when valid and ready were
    // both high going into the edge. The result is checked before the character is noted,
    // although with the result path registered the two can never belong to the same string.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results.valid && results.ready)
                window_board.check_result(results.best_start, results.best_length,
                                          results.overflow);
            if (chars.valid && chars.ready)
                window_board.note_char(chars.char_byte, chars.is_last);
        end
    end

    // Offer one character. A random gap comes first unless the no-idle mode is on; with no
    // gap, valid simply stays high from the previous transfer.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_byte <= c;
        chars.is_last   <= last;
        do
            @(posedge clk);
        while (!(chars.valid && chars.ready));
        chars_sent++;
    endtask

    // Send a whole string given as text, the final character flagged.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Send a random string. Style 0 draws from the whole byte range, style 1 from a
    // narrow band of neighbouring values so that repeats are frequent, and style 2 from
    // six fixed bit patterns, among them both extremes of the byte.
    task automatic send_string(input int len, input int style);
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] c;
        int                band;
        base = CHAR_W'($urandom_range(0, 255));
        band = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: c = CHAR_W'($urandom_range(0, 255));
                1: c = base + CHAR_W'($urandom_range(0, band));
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: c = 8'h00;
                        1: c = 8'hFF;
                        2: c = 8'h55;
                        3: c = 8'hAA;
                        4: c = 8'h01;
                        default: c = 8'h80;
                    endcase
                end
            endcase
            send_char(c, i == len - 1);
        end
    endtask

    // Hold the sender until every expected result has been taken. The offer is withdrawn
    // first so that the character just transferred is not taken a second time, and the task
    // waits on the clock so that the monitor has noted it.
    task automatic wait_for_drain();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (window_board.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver. For every result it draws a random gap with ready low, then serves any
    // hold-off that the stimulus has asked for, then raises ready and waits for the
    // transfer. With no gap and no hold-off, ready stays high throughout.
    initial
    begin
        int gap;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0 || hold_off_cycles > 0)
            begin
                results.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off_cycles > 0)
                begin
                    hold_off_cycles--;
                    @(posedge clk);
                end
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results.valid && results.ready));
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int style;
        int len;
        int next_drain;
        bit pressure_done;

        window_board    = new();
        hold_off_cycles = 0;
        no_idle         = 1'b0;
        chars_sent      = 0;
        pressure_done   = 1'b0;
        next_drain      = 250;

        rst_n           <= 1'b0;
        chars.valid     <= 1'b0;
        chars.char_byte <= '0;
        chars.is_last   <= 1'b0;
        results.ready   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: single characters at both ends of the byte range, the
        // classic examples, a run of one value, and ties between equal windows where
        // the first must be kept.
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("abcabcbb");
        send_text("bbbb");
        send_text("pwwkew");
        send_text("abab");
        send_text("abba");

        // Random strings, mostly short, now and then a few hundred characters long.
        while (chars_sent < 1100)
        begin
            // Long receiver hold-off while short strings keep coming, so that two
            // results wait and the block holds back its input.
            if (!pressure_done && chars_sent > 500)
            begin
                pressure_done   = 1'b1;
                hold_off_cycles = 300;
                no_idle         = 1'b1;
                for (int k = 0; k < 24; k++)
                    send_string($urandom_range(1, 3), $urandom_range(0, 2));
                no_idle = 1'b0;
            end
            // From time to time the sender stops until everything has been taken.
            if (chars_sent >= next_drain)
            begin
                next_drain += 300;
                wait_for_drain();
            end
            style = $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(100, 400);
            else
                len = $urandom_range(1, 24);
            if (len > 1100 - chars_sent)
                len = 1100 - chars_sent;
            no_idle = ($urandom_range(0, 7) == 0);
            send_string(len, style);
        end
        no_idle = 1'b0;
        chars.valid <= 1'b0;

        // Let the last results come out, then allow for the pipeline to settle.
        wait_for_drain();
        repeat (20) @(posedge clk);
        window_board.check_leftovers();

        if (window_board.mismatches == 0)
            $display("longest_unique_char_window_tb passed");
        else
            $display("longest_unique_char_window_tb failed");
        $finish;
    end

    // Watchdog: ends a run that has not finished in time as failed.
    initial
    begin
        #20_000_000;
        $display("longest_unique_char_window_tb failed");
        $finish;
    end

endmodule
